// ----- sv/hfa_pkg.sv -----
// Shared types and constants for the hole fit allocator.
// No dependencies; used by hfa_hole_store and hole_fit_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

  localparam int HOLE_SLOTS     = 32;
  localparam int SIZE_BITS      = 16;
  localparam int ADDR_BITS      = $clog2(HOLE_SLOTS);
  localparam int CNT_BITS       = $clog2(HOLE_SLOTS + 1);
  localparam int SLOT_BITS      = 5;
  localparam int MODE_BITS      = 2;
  localparam int HOLES_BITS     = 6;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 6;

  localparam logic [CNT_BITS-1:0]   HOLE_SLOTS_CNT = CNT_BITS'(HOLE_SLOTS);
  localparam logic [HOLES_BITS-1:0] HOLES_RESET    = HOLES_BITS'(32);

  localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_LOADED = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_PLACED = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NO_FIT = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIT_MODE     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLES_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- sv/hfa_hole_store.sv -----
// Hole size table: synchronous memory with registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on hfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfa_hole_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hfa_pkg::mem_req_t             req,
  output logic [hfa_pkg::SIZE_BITS-1:0]      rd_data
);

  logic [hfa_pkg::SIZE_BITS-1:0]  mem [hfa_pkg::HOLE_SLOTS];
  logic [hfa_pkg::HOLE_SLOTS-1:0] valid_r;
  logic [hfa_pkg::SIZE_BITS-1:0]  rd_word_r;
  logic                           rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_word_r : '0;

endmodule

`default_nettype wire

// ----- sv/hole_fit_allocator_unit.sv -----
// Hole fit allocator top level: config registers, scan sequencer, result register.
// Depends on hfa_pkg and hfa_hole_store.
// Load: ST_FINISH loads the result register once it is free.
// Allocate: ST_SCAN reads the holes in use (saturated at 32), one entry per cycle,
// then ST_FINISH loads the result register. One item in flight, taken in ST_IDLE.
// Synchronous active-low reset clears the table, mode 0, holes_in_use 32.
`timescale 1ns / 1ps
`default_nettype none

module hole_fit_allocator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_op,
  input  wire logic [hfa_pkg::SLOT_BITS-1:0]        in_slot,
  input  wire logic [hfa_pkg::SIZE_BITS-1:0]        in_amount,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [hfa_pkg::STATUS_BITS-1:0]           out_status,
  output logic [hfa_pkg::SLOT_BITS-1:0]             out_chosen_hole,
  output logic [hfa_pkg::SIZE_BITS-1:0]             out_left_over,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [hfa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [hfa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  hfa_pkg::state_t                   state_r, state_nxt;
  logic [hfa_pkg::MODE_BITS-1:0]     fit_mode_r;
  logic [hfa_pkg::HOLES_BITS-1:0]    holes_in_use_r;

  logic                              op_r;
  logic [hfa_pkg::SLOT_BITS-1:0]     slot_r;
  logic [hfa_pkg::SIZE_BITS-1:0]     amount_r;
  logic                              slot_ok_r;
  logic [hfa_pkg::CNT_BITS-1:0]      limit_r;
  logic [hfa_pkg::CNT_BITS-1:0]      rd_idx_r;
  logic                              cmp_valid_r;
  logic [hfa_pkg::ADDR_BITS-1:0]     cmp_idx_r;
  logic                              found_r;
  logic [hfa_pkg::ADDR_BITS-1:0]     pick_r;
  logic [hfa_pkg::SIZE_BITS-1:0]     pick_size_r;

  logic                              out_valid_r;
  logic [hfa_pkg::STATUS_BITS-1:0]   out_status_r;
  logic [hfa_pkg::SLOT_BITS-1:0]     out_chosen_hole_r;
  logic [hfa_pkg::SIZE_BITS-1:0]     out_left_over_r;

  hfa_pkg::mem_req_t                 mem_req;
  logic [hfa_pkg::SIZE_BITS-1:0]     rd_data;

  logic                              in_xfer;
  logic                              slot_ok;
  logic                              issue;
  logic                              scan_done;
  logic                              out_free;
  logic                              out_load;
  logic                              fits;
  logic                              take;
  logic [hfa_pkg::SIZE_BITS-1:0]     shrunk;
  logic [hfa_pkg::CNT_BITS-1:0]      limit_sat;
  logic [hfa_pkg::STATUS_BITS-1:0]   res_status;
  logic [hfa_pkg::SLOT_BITS-1:0]     res_hole;
  logic [hfa_pkg::SIZE_BITS-1:0]     res_left;

  hfa_hole_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r     <= hfa_pkg::FIT_FIRST;
      holes_in_use_r <= hfa_pkg::HOLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hfa_pkg::REG_FIT_MODE:     fit_mode_r     <= cfg_data[hfa_pkg::MODE_BITS-1:0];
        hfa_pkg::REG_HOLES_IN_USE: holes_in_use_r <= cfg_data[hfa_pkg::HOLES_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake and control terms
  assign in_ready  = (state_r == hfa_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_ok   = ({1'b0, in_slot} < hfa_pkg::HOLE_SLOTS_CNT);
  assign issue     = (state_r == hfa_pkg::ST_SCAN) && (rd_idx_r < limit_r);
  assign scan_done = (rd_idx_r == limit_r) && !cmp_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == hfa_pkg::ST_FINISH) && out_free;
  assign shrunk    = pick_size_r - amount_r;
  assign limit_sat = (holes_in_use_r > hfa_pkg::HOLE_SLOTS_CNT) ?
                     hfa_pkg::HOLE_SLOTS_CNT : holes_in_use_r;

  // candidate selection
  assign fits = (rd_data >= amount_r);

  always_comb begin
    take = 1'b0;
    if (cmp_valid_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (fit_mode_r)
          hfa_pkg::FIT_FIRST: take = 1'b0;
          hfa_pkg::FIT_BEST:  take = (rd_data < pick_size_r);
          default:            take = (rd_data > pick_size_r);
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hfa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_op == hfa_pkg::OP_ALLOC) ? hfa_pkg::ST_SCAN : hfa_pkg::ST_FINISH;
        end
      end
      hfa_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = hfa_pkg::ST_FINISH;
        end
      end
      hfa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = hfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hfa_pkg::ST_IDLE;
    endcase
  end

  // memory port and result fields
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = issue;
    mem_req.rd_addr = rd_idx_r[hfa_pkg::ADDR_BITS-1:0];
    unique case (state_r)
      hfa_pkg::ST_IDLE: begin
        if (in_xfer && (in_op == hfa_pkg::OP_LOAD) && slot_ok) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = in_slot[hfa_pkg::ADDR_BITS-1:0];
          mem_req.wr_data = in_amount;
        end
      end
      hfa_pkg::ST_FINISH: begin
        if (out_free && (op_r == hfa_pkg::OP_ALLOC) && found_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pick_r;
          mem_req.wr_data = shrunk;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (op_r == hfa_pkg::OP_LOAD) begin
      res_status = hfa_pkg::STAT_LOADED;
      res_hole   = slot_r;
      res_left   = slot_ok_r ? amount_r : '0;
    end else if (found_r) begin
      res_status = hfa_pkg::STAT_PLACED;
      res_hole   = hfa_pkg::SLOT_BITS'(pick_r);
      res_left   = shrunk;
    end else begin
      res_status = hfa_pkg::STAT_NO_FIT;
      res_hole   = '0;
      res_left   = '0;
    end
  end

  // state and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hfa_pkg::ST_IDLE;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        rd_idx_r    <= '0;
        cmp_valid_r <= 1'b0;
        found_r     <= 1'b0;
      end else if (state_r == hfa_pkg::ST_SCAN) begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + hfa_pkg::CNT_BITS'(1);
        end
        cmp_valid_r <= issue;
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_op;
      slot_r    <= in_slot;
      amount_r  <= in_amount;
      slot_ok_r <= slot_ok;
      limit_r   <= limit_sat;
    end
    if (issue) begin
      cmp_idx_r <= rd_idx_r[hfa_pkg::ADDR_BITS-1:0];
    end
    if (take) begin
      pick_r      <= cmp_idx_r;
      pick_size_r <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r      <= res_status;
      out_chosen_hole_r <= res_hole;
      out_left_over_r   <= res_left;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_hole = out_chosen_hole_r;
  assign out_left_over   = out_left_over_r;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("hole table read and write in the same cycle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hfa_pkg::ST_SCAN) |-> (rd_idx_r <= limit_r))
    else $error("scan index ran past the holes in use");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == hfa_pkg::ST_FINISH) && (op_r == hfa_pkg::OP_ALLOC) && found_r)
      |-> ({1'b0, pick_r} < limit_r))
    else $error("chosen hole outside the searched range");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != hfa_pkg::ST_IDLE))
    else $error("item transfer did not start work");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for hole_fit_allocator_unit: a directed table, then random load and
// allocate traffic, each result checked against a fixed value or the in-bench table model.
// Depends on hfa_pkg and hole_fit_allocator_unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct packed {
    logic [hfa_pkg::STATUS_BITS-1:0] status;
    logic [hfa_pkg::SLOT_BITS-1:0]   hole;
    logic [hfa_pkg::SIZE_BITS-1:0]   left;
  } alloc_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic                               op;
    logic [hfa_pkg::SLOT_BITS-1:0]      slot;
    logic [hfa_pkg::SIZE_BITS-1:0]      amount;
    logic [hfa_pkg::CFG_INDEX_BITS-1:0] reg_index;
    logic [hfa_pkg::CFG_DATA_BITS-1:0]  reg_data;
    logic                               fixed;
    alloc_result_t                      exp;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_op = 1'b0;
  logic [hfa_pkg::SLOT_BITS-1:0]      in_slot = '0;
  logic [hfa_pkg::SIZE_BITS-1:0]      in_amount = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [hfa_pkg::STATUS_BITS-1:0]    out_status;
  logic [hfa_pkg::SLOT_BITS-1:0]      out_chosen_hole;
  logic [hfa_pkg::SIZE_BITS-1:0]      out_left_over;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [hfa_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [hfa_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic [hfa_pkg::SIZE_BITS-1:0]  model_holes [hfa_pkg::HOLE_SLOTS];
  logic [hfa_pkg::MODE_BITS-1:0]  model_mode;
  logic [hfa_pkg::HOLES_BITS-1:0] model_in_use;

  alloc_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 27;
  int unsigned   recv_idle_pct = 58;

  hole_fit_allocator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_chosen_hole (out_chosen_hole),
    .out_left_over   (out_left_over),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic alloc_result_t compute_allocation(
      input logic op,
      input logic [hfa_pkg::SLOT_BITS-1:0] slot,
      input logic [hfa_pkg::SIZE_BITS-1:0] amount);
    alloc_result_t                 res;
    int                            limit;
    int                            pick;
    logic [hfa_pkg::SIZE_BITS-1:0] pick_size;
    logic                          found;
    logic                          take;
    res = '0;
    if (op == hfa_pkg::OP_LOAD) begin
      res.status = hfa_pkg::STAT_LOADED;
      res.hole = slot;
      if (int'(slot) < hfa_pkg::HOLE_SLOTS) begin
        model_holes[slot] = amount;
        res.left = amount;
      end
      return res;
    end
    limit = (int'(model_in_use) > hfa_pkg::HOLE_SLOTS) ?
            hfa_pkg::HOLE_SLOTS : int'(model_in_use);
    pick = 0;
    pick_size = '0;
    found = 1'b0;
    for (int k = 0; k < limit; k++) begin
      if (model_holes[k] >= amount) begin
        if (!found) begin
          take = 1'b1;
        end else if (model_mode == hfa_pkg::FIT_FIRST) begin
          take = 1'b0;
        end else if (model_mode == hfa_pkg::FIT_BEST) begin
          take = model_holes[k] < pick_size;
        end else begin
          take = model_holes[k] > pick_size;
        end
        if (take) begin
          found = 1'b1;
          pick = k;
          pick_size = model_holes[k];
        end
      end
    end
    if (!found) begin
      res.status = hfa_pkg::STAT_NO_FIT;
      return res;
    end
    model_holes[pick] = pick_size - amount;
    res.status = hfa_pkg::STAT_PLACED;
    res.hole = hfa_pkg::SLOT_BITS'(pick);
    res.left = model_holes[pick];
    return res;
  endfunction

  function automatic void add_row_item(input logic op,
                                       input logic [hfa_pkg::SLOT_BITS-1:0] slot,
                                       input logic [hfa_pkg::SIZE_BITS-1:0] amount,
                                       input logic fixed,
                                       input logic [hfa_pkg::STATUS_BITS-1:0] status,
                                       input logic [hfa_pkg::SLOT_BITS-1:0] hole,
                                       input logic [hfa_pkg::SIZE_BITS-1:0] left);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.slot = slot;
    row.amount = amount;
    row.fixed = fixed;
    row.exp = '{status: status, hole: hole, left: left};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_row_reg(input logic [hfa_pkg::CFG_INDEX_BITS-1:0] index,
                                      input logic [hfa_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_index = index;
    row.reg_data = data;
    directed_rows.push_back(row);
  endfunction

  // hold off input until every outstanding result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic push_request(input logic op, input logic [hfa_pkg::SLOT_BITS-1:0] slot,
                              input logic [hfa_pkg::SIZE_BITS-1:0] amount,
                              input logic fixed, input alloc_result_t fixed_res);
    alloc_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_slot <= slot;
    in_amount <= amount;
    do @(posedge clk); while (!in_ready);
    res = compute_allocation(op, slot, amount);
    pending_results.push_back(fixed ? fixed_res : res);
  endtask

  task automatic write_reg(input logic [hfa_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [hfa_pkg::CFG_DATA_BITS-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == hfa_pkg::REG_FIT_MODE) begin
      model_mode = data[hfa_pkg::MODE_BITS-1:0];
    end else begin
      model_in_use = data;
    end
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, chosen_hole %0d, left_over %0d",
               out_status, out_chosen_hole, out_left_over);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_chosen_hole !== want.hole) begin
          $error("chosen_hole: expected %0d, actual %0d", want.hole, out_chosen_hole);
          mismatches++;
        end
        if (out_left_over !== want.left) begin
          $error("left_over: expected %0d, actual %0d", want.left, out_left_over);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : stimulus
    stim_row_t                     row;
    int                            holes_plan [PHASES];
    int                            limit;
    int unsigned                   pick;
    logic                          op;
    logic [hfa_pkg::SLOT_BITS-1:0] slot;
    logic [hfa_pkg::SIZE_BITS-1:0] amount;
    holes_plan = '{32, 1, 63, 8, 0, 32, 2, 33, 17};
    for (int k = 0; k < hfa_pkg::HOLE_SLOTS; k++) begin
      model_holes[k] = '0;
    end
    model_mode = hfa_pkg::FIT_FIRST;
    model_in_use = hfa_pkg::HOLES_RESET;

    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd0, 1'b1, hfa_pkg::STAT_PLACED, 5'd0, 16'd0);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd31, 16'd1, 1'b1, hfa_pkg::STAT_NO_FIT, 5'd0, 16'd0);
    add_row_item(hfa_pkg::OP_LOAD, 5'd0, 16'hffff, 1'b1, hfa_pkg::STAT_LOADED, 5'd0, 16'hffff);
    add_row_item(hfa_pkg::OP_LOAD, 5'd31, 16'hffff, 1'b1, hfa_pkg::STAT_LOADED, 5'd31,
                 16'hffff);
    add_row_item(hfa_pkg::OP_LOAD, 5'd5, 16'd100, 1'b1, hfa_pkg::STAT_LOADED, 5'd5, 16'd100);
    add_row_item(hfa_pkg::OP_LOAD, 5'd10, 16'd300, 1'b1, hfa_pkg::STAT_LOADED, 5'd10, 16'd300);
    add_row_item(hfa_pkg::OP_LOAD, 5'd20, 16'd200, 1'b1, hfa_pkg::STAT_LOADED, 5'd20, 16'd200);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'hffff, 1'b1, hfa_pkg::STAT_PLACED, 5'd0, 16'd0);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd31, 16'd50, 1'b0, '0, '0, '0);
    add_row_reg(hfa_pkg::REG_FIT_MODE, hfa_pkg::CFG_DATA_BITS'(hfa_pkg::FIT_BEST));
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd100, 1'b0, '0, '0, '0);
    add_row_reg(hfa_pkg::REG_FIT_MODE, hfa_pkg::CFG_DATA_BITS'(hfa_pkg::FIT_WORST));
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd1, 1'b0, '0, '0, '0);
    add_row_reg(hfa_pkg::REG_FIT_MODE, 6'h3f);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd31, 16'd2, 1'b0, '0, '0, '0);
    add_row_reg(hfa_pkg::REG_HOLES_IN_USE, 6'd0);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd0, 1'b1, hfa_pkg::STAT_NO_FIT, 5'd0, 16'd0);
    add_row_reg(hfa_pkg::REG_HOLES_IN_USE, 6'd63);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd1, 1'b0, '0, '0, '0);
    add_row_reg(hfa_pkg::REG_FIT_MODE, hfa_pkg::CFG_DATA_BITS'(hfa_pkg::FIT_FIRST));
    add_row_reg(hfa_pkg::REG_HOLES_IN_USE, 6'd1);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd0, 1'b1, hfa_pkg::STAT_PLACED, 5'd0, 16'd0);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd1, 1'b1, hfa_pkg::STAT_NO_FIT, 5'd0, 16'd0);
    add_row_reg(hfa_pkg::REG_HOLES_IN_USE, 6'd32);
    add_row_item(hfa_pkg::OP_LOAD, 5'd3, 16'd7, 1'b1, hfa_pkg::STAT_LOADED, 5'd3, 16'd7);
    add_row_item(hfa_pkg::OP_LOAD, 5'd4, 16'd7, 1'b1, hfa_pkg::STAT_LOADED, 5'd4, 16'd7);
    add_row_reg(hfa_pkg::REG_FIT_MODE, hfa_pkg::CFG_DATA_BITS'(hfa_pkg::FIT_BEST));
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd7, 1'b0, '0, '0, '0);
    add_row_item(hfa_pkg::OP_ALLOC, 5'd0, 16'd7, 1'b0, '0, '0, '0);

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_index, row.reg_data);
      end else begin
        push_request(row.op, row.slot, row.amount, row.fixed, row.exp);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(hfa_pkg::REG_FIT_MODE, {4'($urandom_range(15)), 2'(phase % 4)});
      write_reg(hfa_pkg::REG_HOLES_IN_USE, hfa_pkg::CFG_DATA_BITS'(holes_plan[phase]));
      case (phase / 3)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      limit = (int'(model_in_use) > hfa_pkg::HOLE_SLOTS) ?
              hfa_pkg::HOLE_SLOTS : int'(model_in_use);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        op = ($urandom_range(99) < 45) ? hfa_pkg::OP_LOAD : hfa_pkg::OP_ALLOC;
        if (limit > 0 && $urandom_range(99) < 80) begin
          slot = hfa_pkg::SLOT_BITS'($urandom_range(limit - 1));
        end else begin
          slot = hfa_pkg::SLOT_BITS'($urandom);
        end
        pick = $urandom_range(99);
        if (op == hfa_pkg::OP_LOAD) begin
          if (pick < 5) amount = '0;
          else if (pick < 10) amount = '1;
          else if (pick < 35) amount = hfa_pkg::SIZE_BITS'($urandom_range(1023));
          else amount = hfa_pkg::SIZE_BITS'($urandom);
        end else begin
          if (pick < 10) amount = '0;
          else if (pick < 15) amount = '1;
          else if (pick < 55) amount = hfa_pkg::SIZE_BITS'($urandom_range(255));
          else amount = hfa_pkg::SIZE_BITS'($urandom);
        end
        push_request(op, slot, amount, 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
